FILE: rtl/lctcb_pkg.sv
// Shared types and constants for the LUT cover to configuration bits block.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package lctcb_pkg;

  localparam int LutInputs = 6;
  localparam int ImgSize   = 1 << LutInputs;
  localparam int OutW      = 64;
  localparam int CareW     = 6;
  localparam int FracW     = 3;
  localparam int SegW      = 6;
  localparam int InDataW   = 24;
  localparam int EndW      = SegW + 1 + (1 << FracW) - 1;

  localparam logic KindLine  = 1'b0;
  localparam logic KindEmpty = 1'b1;

  typedef logic [ImgSize-1:0] img_t;

  typedef struct packed {
    logic             kind;
    logic [CareW-1:0] care_mask;
    logic [CareW-1:0] line_bits;
    logic             line_output;
    logic             last_line;
    logic [FracW-1:0] len_log2;
    logic [SegW-1:0]  segment;
    logic             last_table;
  } item_t;

  typedef struct packed {
    logic in_range;
    img_t mask;
  } seg_t;

  typedef struct packed {
    logic emit;
    img_t lut_bits;
    logic range_error;
  } result_t;

endpackage

FILE: rtl/lut_cover_to_config_bits.sv
// Top level of the LUT cover to configuration bits block: input and result registers.
// Depends on lctcb_pkg and lctcb_core.
//
// Each input beat carries one cube of a sum-of-products cover, or a marker for a
// table that has no lines. The block builds the truth table of each output, copies
// it into its segment of the LUT image and sends the finished image as one result
// beat when the table flagged as the last one of the LUT closes.
// Input beats enter a one-deep input register; the cube decode, table update and
// segment merge run combinationally from it; the result register is loaded when
// the last table's closing beat leaves that register. Unless a result stall holds
// input, one beat is accepted and the table state loop updates every cycle.
// While a result waits on a stalled receiver, beats that produce no result still
// flow; the next result-producing beat waits in the input register and holds back
// further input until the receiver takes the pending result.
// Reset clears all table and image state and sets the default bit to zero; the user
// must write it via cfg_we and cfg_wdata only while idle, which is not enforced.
module lut_cover_to_config_bits (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_wdata,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // care_mask[5:0], line_bits[11:6], line_output[12], len_log2[15:13],
  // segment[21:16], last_table[22], zero pad[23]
  input  logic [lctcb_pkg::InDataW-1:0] s_axis_tdata,
  // kind
  input  logic                          s_axis_tuser,
  // last_line
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // lut_bits[63:0]
  output logic [lctcb_pkg::OutW-1:0]    m_axis_tdata,
  // range_error
  output logic                          m_axis_tuser
);

  logic               default_bit;
  logic               in_valid;
  lctcb_pkg::item_t   item;
  lctcb_pkg::result_t result;
  logic               out_free;
  logic               fire;

  assign out_free      = ~m_axis_tvalid | m_axis_tready;
  assign fire          = in_valid & (out_free | ~result.emit);
  assign s_axis_tready = ~in_valid | fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_bit <= 1'b0;
    end else if (cfg_we) begin
      default_bit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item.kind        <= s_axis_tuser;
      item.care_mask   <= s_axis_tdata[5:0];
      item.line_bits   <= s_axis_tdata[11:6];
      item.line_output <= s_axis_tdata[12];
      item.last_line   <= s_axis_tlast;
      item.len_log2    <= s_axis_tdata[15:13];
      item.segment     <= s_axis_tdata[21:16];
      item.last_table  <= s_axis_tdata[22];
    end
  end

  lctcb_core u_core (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .item        (item),
    .default_bit (default_bit),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (fire && result.emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && result.emit) begin
      m_axis_tdata <= lctcb_pkg::OutW'(result.lut_bits);
      m_axis_tuser <= result.range_error;
    end
  end

endmodule

FILE: rtl/lctcb_cube.sv
// Cube decoder: marks every image entry that one cover line writes.
// Depends on lctcb_pkg.
module lctcb_cube (
  input  logic [lctcb_pkg::CareW-1:0] care_mask,
  input  logic [lctcb_pkg::CareW-1:0] line_bits,
  output lctcb_pkg::img_t             hits
);

  logic [lctcb_pkg::LutInputs-1:0] care;
  logic [lctcb_pkg::LutInputs-1:0] want;

  assign care = care_mask[lctcb_pkg::LutInputs-1:0];
  assign want = ~line_bits[lctcb_pkg::LutInputs-1:0] & care;

  always_comb begin
    for (int j = 0; j < lctcb_pkg::ImgSize; j++) begin
      hits[j] = ((lctcb_pkg::LutInputs'(j) ^ want) & care) == '0;
    end
  end

endmodule

FILE: rtl/lctcb_segmask.sv
// Segment decoder: range check and bit mask of a table's segment in the image.
// Depends on lctcb_pkg.
module lctcb_segmask (
  input  logic [lctcb_pkg::FracW-1:0] len_log2,
  input  logic [lctcb_pkg::SegW-1:0]  segment,
  output lctcb_pkg::seg_t             seg
);

  logic [lctcb_pkg::EndW-1:0]  end_pos;
  logic [lctcb_pkg::EndW-1:0]  offset;
  logic [lctcb_pkg::EndW-1:0]  seg_len;
  logic [lctcb_pkg::ImgSize:0] span;

  always_comb begin
    seg_len      = lctcb_pkg::EndW'(1) << len_log2;
    offset       = lctcb_pkg::EndW'(segment) << len_log2;
    end_pos      = (lctcb_pkg::EndW'(segment) + lctcb_pkg::EndW'(1)) << len_log2;
    span         = ((lctcb_pkg::ImgSize + 1)'(1) << seg_len)
                   - (lctcb_pkg::ImgSize + 1)'(1);
    seg.in_range = end_pos <= lctcb_pkg::EndW'(lctcb_pkg::ImgSize);
    seg.mask     = span[lctcb_pkg::ImgSize-1:0] << offset[lctcb_pkg::LutInputs-1:0];
  end

endmodule

FILE: rtl/lctcb_core.sv
// Table and image state: applies one cover line or table close per beat.
// Depends on lctcb_pkg, lctcb_cube and lctcb_segmask.
module lctcb_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  lctcb_pkg::item_t   item,
  input  logic               default_bit,
  output lctcb_pkg::result_t result
);

  lctcb_pkg::img_t image;
  lctcb_pkg::img_t written;
  lctcb_pkg::img_t values;
  logic            saw_on_line;
  logic            saw_any_line;
  logic            lut_started;
  logic            error_seen;

  lctcb_pkg::img_t hits;
  lctcb_pkg::seg_t seg;
  lctcb_pkg::img_t img_cur;
  lctcb_pkg::img_t written_next;
  lctcb_pkg::img_t values_next;
  lctcb_pkg::img_t table_img;
  lctcb_pkg::img_t img_closed;
  logic            err_cur;
  logic            err_closed;
  logic            is_line;
  logic            closing;
  logic            on_next;
  logic            any_next;
  logic            base;

  lctcb_cube u_cube (
    .care_mask (item.care_mask),
    .line_bits (item.line_bits),
    .hits      (hits)
  );

  lctcb_segmask u_segmask (
    .len_log2 (item.len_log2),
    .segment  (item.segment),
    .seg      (seg)
  );

  always_comb begin
    img_cur      = lut_started ? image : (default_bit ? '1 : '0);
    err_cur      = lut_started & error_seen;
    is_line      = item.kind == lctcb_pkg::KindLine;
    closing      = (item.kind == lctcb_pkg::KindEmpty) | item.last_line;
    written_next = is_line ? (written | hits) : written;
    if (!is_line) begin
      values_next = values;
    end else if (item.line_output) begin
      values_next = values | hits;
    end else begin
      values_next = values & ~hits;
    end
    on_next    = saw_on_line | (is_line & item.line_output);
    any_next   = saw_any_line | is_line;
    base       = any_next ? ~on_next : default_bit;
    table_img  = (values_next & written_next) | (base ? ~written_next : '0);
    img_closed = seg.in_range ? ((img_cur & ~seg.mask) | (table_img & seg.mask)) : img_cur;
    err_closed = err_cur | ~seg.in_range;

    result.emit        = closing & item.last_table;
    result.lut_bits    = img_closed;
    result.range_error = err_closed;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image        <= '0;
      written      <= '0;
      values       <= '0;
      saw_on_line  <= 1'b0;
      saw_any_line <= 1'b0;
      lut_started  <= 1'b0;
      error_seen   <= 1'b0;
    end else if (fire) begin
      if (closing) begin
        written      <= '0;
        values       <= '0;
        saw_on_line  <= 1'b0;
        saw_any_line <= 1'b0;
        if (item.last_table) begin
          image       <= '0;
          lut_started <= 1'b0;
          error_seen  <= 1'b0;
        end else begin
          image       <= img_closed;
          lut_started <= 1'b1;
          error_seen  <= err_closed;
        end
      end else begin
        written      <= written_next;
        values       <= values_next;
        saw_on_line  <= on_next;
        saw_any_line <= any_next;
        image        <= img_cur;
        lut_started  <= 1'b1;
        error_seen   <= err_cur;
      end
    end
  end

endmodule
